@@ rtl/tnc_pkg.sv @@
// Shared types and constants for the triangle normal and centroid core.
package tnc_pkg;

  localparam int unsigned ACC_W     = 98;   // cell accumulator width, holds 4*c^2*s
  localparam int unsigned NUM_CELLS = 15;   // one cell per quotient bit, Q1.14 plus one
  localparam int unsigned FRONT_STAGES = 9;
  localparam int unsigned LATENCY   = FRONT_STAGES + NUM_CELLS + 1;

  localparam logic [15:0] ONE_Q14    = 16'd16384;
  // floor(x/3) = (x * CEN_RECIP) >> 35 for x < 2^33
  localparam logic [33:0] CEN_RECIP  = 34'd11453246123;

  localparam logic REG_GIVEN_MIN = 1'b0;
  localparam logic REG_CROSS_MIN = 1'b1;

  typedef struct packed {
    logic [14:0]      q;      // quotient bits decided so far
    logic [ACC_W-1:0] acc_a;  // q^2 * s
    logic [ACC_W-1:0] acc_b;  // q * s
    logic [ACC_W-1:0] r;      // a^2 << 30
    logic             neg;
  } tnc_lane_t;

  typedef struct packed {
    logic [2:0][31:0] cen;
    logic             computed;
    logic             degen;
    logic             zero;
  } tnc_side_t;

endpackage

@@ rtl/tnc_front.sv @@
// Front pipeline: edges, cross product, thresholds, centroid, normalize, square.
module tnc_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [2:0][31:0]         va_i,
  input  logic [2:0][31:0]         vb_i,
  input  logic [2:0][31:0]         vc_i,
  input  logic [2:0][31:0]         gn_i,
  input  logic [31:0]              gmin_i,
  input  logic [31:0]              cmin_i,
  output logic                     valid_o,
  output logic [63:0]              s_o,
  output tnc_pkg::tnc_lane_t [2:0] lane_o,
  output tnc_pkg::tnc_side_t       side_o
);
  import tnc_pkg::*;

  logic [9:1] v_q;

  // F1
  logic [2:0][31:0] a1_q, b1_q, c1_q, g1_q;
  // F2
  logic [2:0][32:0] u2_d, u2_q, w2_d, w2_q;
  logic [2:0][33:0] sum2_d, sum2_q;
  logic [2:0][31:0] gm2_d, gm2_q;
  logic [2:0]       gneg2_q;
  // F3
  logic [2:0][32:0] mu, mw;
  logic [2:0][65:0] pm3_d, pm3_q, qm3_d, qm3_q;
  logic [2:0]       ps3_d, ps3_q, qs3_d, qs3_q;
  logic [2:0][63:0] gsq3_d, gsq3_q;
  logic [2:0][32:0] cx;
  logic [2:0][31:0] quo3_d, quo3_q, gm3_q;
  logic [2:0]       cneg3_q, gneg3_q;
  logic [63:0]      lim3_q, tcr3_q;
  // F4
  logic [2:0][65:0] cm4_d, cm4_q;
  logic [2:0]       xneg4_d, xneg4_q, gneg4_q;
  logic [63:0]      gs4_d, gs4_q, tcr4_q;
  logic             useg4_q;
  logic [2:0][31:0] gm4_q, cen4_d, cen4_q;
  // F5
  logic [65:0]      cmax;
  logic [6:0]       blen;
  logic [5:0]       sh5_d, sh5_q;
  logic [2:0][47:0] hh5_d, hh5_q, hl5_d, hl5_q, ll5_d, ll5_q;
  logic [2:0][65:0] cm5_q;
  logic [2:0]       xneg5_q, gneg5_q;
  logic             small5_q, useg5_q;
  logic [63:0]      gs5_q, tcr5_q;
  logic [2:0][31:0] gm5_q, cen5_q;
  // F6
  logic [2:0][95:0] sq6_d, sq6_q;
  logic [2:0][30:0] red6_d, red6_q;
  logic [2:0]       xneg6_q, gneg6_q;
  logic             small6_q, useg6_q;
  logic [63:0]      gs6_q, tcr6_q;
  logic [2:0][31:0] gm6_q, cen6_q;
  // F7
  logic [97:0]      tot7;
  logic             degen7_q;
  logic [2:0][61:0] rsq7_d, rsq7_q;
  logic [2:0][30:0] red7_q;
  logic [2:0]       xneg7_q, gneg7_q;
  logic             useg7_q;
  logic [63:0]      gs7_q;
  logic [2:0][31:0] gm7_q, cen7_q;
  // F8
  logic [63:0]      rs8, s8_d, s8_q;
  logic [2:0][31:0] a8_q;
  logic [2:0]       neg8_q;
  tnc_side_t        side8_d, side8_q;
  // F9
  logic [63:0]      s9_q;
  tnc_lane_t [2:0]  lane9_d, lane9_q;
  tnc_side_t        side9_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u2_d[i]   = {b1_q[i][31], b1_q[i]} - {a1_q[i][31], a1_q[i]};
      w2_d[i]   = {c1_q[i][31], c1_q[i]} - {a1_q[i][31], a1_q[i]};
      sum2_d[i] = {{2{a1_q[i][31]}}, a1_q[i]} + {{2{b1_q[i][31]}}, b1_q[i]}
                + {{2{c1_q[i][31]}}, c1_q[i]};
      gm2_d[i]  = g1_q[i][31] ? (32'd0 - g1_q[i]) : g1_q[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mu[i] = u2_q[i][32] ? (33'd0 - u2_q[i]) : u2_q[i];
      mw[i] = w2_q[i][32] ? (33'd0 - w2_q[i]) : w2_q[i];
    end
    for (int i = 0; i < 3; i++) begin
      pm3_d[i]  = 66'(mu[(i+1)%3]) * 66'(mw[(i+2)%3]);
      qm3_d[i]  = 66'(mu[(i+2)%3]) * 66'(mw[(i+1)%3]);
      ps3_d[i]  = u2_q[(i+1)%3][32] ^ w2_q[(i+2)%3][32];
      qs3_d[i]  = !(u2_q[(i+2)%3][32] ^ w2_q[(i+1)%3][32]);
      gsq3_d[i] = 64'(gm2_q[i]) * 64'(gm2_q[i]);
      cx[i]     = 33'((sum2_q[i][33] ? (34'd0 - sum2_q[i]) : sum2_q[i]) + 34'd1);
      quo3_d[i] = 32'((67'(cx[i]) * 67'(CEN_RECIP)) >> 35);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ps3_q[i] == qs3_q[i]) begin
        cm4_d[i] = pm3_q[i] + qm3_q[i];
        xneg4_d[i] = ps3_q[i];
      end else if (pm3_q[i] >= qm3_q[i]) begin
        cm4_d[i] = pm3_q[i] - qm3_q[i];
        xneg4_d[i] = ps3_q[i];
      end else begin
        cm4_d[i] = qm3_q[i] - pm3_q[i];
        xneg4_d[i] = qs3_q[i];
      end
      cen4_d[i] = cneg3_q[i] ? (32'd0 - quo3_q[i]) : quo3_q[i];
    end
    gs4_d = gsq3_q[0] + gsq3_q[1] + gsq3_q[2];
  end

  always_comb begin
    cmax = cm4_q[0];
    if (cm4_q[1] > cmax) cmax = cm4_q[1];
    if (cm4_q[2] > cmax) cmax = cm4_q[2];
    blen = 7'd0;
    for (int i = 0; i < 66; i++) begin
      if (cmax[i]) blen = 7'(i + 1);
    end
    sh5_d = (blen > 7'd31) ? 6'(blen - 7'd31) : 6'd0;
    for (int i = 0; i < 3; i++) begin
      hh5_d[i] = 48'(cm4_q[i][47:24]) * 48'(cm4_q[i][47:24]);
      hl5_d[i] = 48'(cm4_q[i][47:24]) * 48'(cm4_q[i][23:0]);
      ll5_d[i] = 48'(cm4_q[i][23:0]) * 48'(cm4_q[i][23:0]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq6_d[i]  = (96'(hh5_q[i]) << 48) + (96'(hl5_q[i]) << 25) + 96'(ll5_q[i]);
      red6_d[i] = 31'(cm5_q[i] >> sh5_q);
      rsq7_d[i] = 62'(red6_q[i]) * 62'(red6_q[i]);
    end
    tot7 = 98'(sq6_q[0]) + 98'(sq6_q[1]) + 98'(sq6_q[2]);
  end

  always_comb begin
    rs8  = 64'(rsq7_q[0]) + 64'(rsq7_q[1]) + 64'(rsq7_q[2]);
    s8_d = useg7_q ? gs7_q : rs8;
    side8_d.cen      = cen7_q;
    side8_d.computed = !useg7_q;
    side8_d.degen    = !useg7_q && degen7_q;
    side8_d.zero     = (!useg7_q && degen7_q) || (s8_d == 64'd0);
    for (int i = 0; i < 3; i++) begin
      lane9_d[i].q     = 15'd0;
      lane9_d[i].acc_a = '0;
      lane9_d[i].acc_b = '0;
      lane9_d[i].r     = ACC_W'(64'(a8_q[i]) * 64'(a8_q[i])) << 30;
      lane9_d[i].neg   = neg8_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[8:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q <= va_i; b1_q <= vb_i; c1_q <= vc_i; g1_q <= gn_i;

    u2_q <= u2_d; w2_q <= w2_d; sum2_q <= sum2_d; gm2_q <= gm2_d;
    for (int i = 0; i < 3; i++) gneg2_q[i] <= g1_q[i][31];

    pm3_q <= pm3_d; qm3_q <= qm3_d; ps3_q <= ps3_d; qs3_q <= qs3_d;
    gsq3_q <= gsq3_d; quo3_q <= quo3_d; gm3_q <= gm2_q; gneg3_q <= gneg2_q;
    for (int i = 0; i < 3; i++) cneg3_q[i] <= sum2_q[i][33];
    lim3_q <= 64'(gmin_i) * 64'(gmin_i);
    tcr3_q <= 64'(cmin_i) * 64'(cmin_i);

    cm4_q <= cm4_d; xneg4_q <= xneg4_d; gs4_q <= gs4_d; useg4_q <= (gs4_d > lim3_q);
    gm4_q <= gm3_q; gneg4_q <= gneg3_q; cen4_q <= cen4_d; tcr4_q <= tcr3_q;

    cm5_q <= cm4_q; xneg5_q <= xneg4_q; sh5_q <= sh5_d; small5_q <= (cmax[65:48] == '0);
    hh5_q <= hh5_d; hl5_q <= hl5_d; ll5_q <= ll5_d;
    gs5_q <= gs4_q; useg5_q <= useg4_q; gm5_q <= gm4_q; gneg5_q <= gneg4_q;
    cen5_q <= cen4_q; tcr5_q <= tcr4_q;

    sq6_q <= sq6_d; red6_q <= red6_d; small6_q <= small5_q; xneg6_q <= xneg5_q;
    gs6_q <= gs5_q; useg6_q <= useg5_q; gm6_q <= gm5_q; gneg6_q <= gneg5_q;
    cen6_q <= cen5_q; tcr6_q <= tcr5_q;

    degen7_q <= small6_q && (tot7 <= {2'b00, tcr6_q, 32'd0});
    rsq7_q <= rsq7_d; red7_q <= red6_q; xneg7_q <= xneg6_q;
    gs7_q <= gs6_q; useg7_q <= useg6_q; gm7_q <= gm6_q; gneg7_q <= gneg6_q;
    cen7_q <= cen6_q;

    s8_q <= s8_d; side8_q <= side8_d;
    for (int i = 0; i < 3; i++) begin
      a8_q[i]   <= useg7_q ? gm7_q[i] : {1'b0, red7_q[i]};
      neg8_q[i] <= useg7_q ? gneg7_q[i] : xneg7_q[i];
    end

    s9_q <= s8_q; lane9_q <= lane9_d; side9_q <= side8_q;
  end

  assign valid_o = v_q[9];
  assign s_o     = s9_q;
  assign lane_o  = lane9_q;
  assign side_o  = side9_q;

endmodule

@@ rtl/tnc_cell.sv @@
// One quotient-bit cell of the unit-scaling chain, three lanes side by side.
module tnc_cell #(
  parameter int unsigned BIT = 14
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [63:0]              s_i,
  input  tnc_pkg::tnc_lane_t [2:0] lane_i,
  input  tnc_pkg::tnc_side_t       side_i,
  output logic                     valid_o,
  output logic [63:0]              s_o,
  output tnc_pkg::tnc_lane_t [2:0] lane_o,
  output tnc_pkg::tnc_side_t       side_o
);
  import tnc_pkg::*;

  logic [ACC_W-1:0]       s_ext;
  logic [2:0][15:0]       c;
  logic [2:0][ACC_W-1:0]  cs, c2s, o2s;
  tnc_lane_t [2:0]        lane_d;
  logic                   valid_q;
  logic [63:0]            s_q;
  tnc_lane_t [2:0]        lane_q;
  tnc_side_t              side_q;

  // try c = q + 2^BIT; keep it if c <= ONE_Q14 and (2c-1)^2 * s <= a^2 * 2^30
  always_comb begin
    s_ext = ACC_W'(s_i);
    for (int l = 0; l < 3; l++) begin
      c[l]   = {1'b0, lane_i[l].q} + (16'd1 << BIT);
      cs[l]  = lane_i[l].acc_b + (s_ext << BIT);
      c2s[l] = lane_i[l].acc_a + (lane_i[l].acc_b << (BIT + 1)) + (s_ext << (2 * BIT));
      o2s[l] = (c2s[l] << 2) - (cs[l] << 2) + s_ext;
      lane_d[l] = lane_i[l];
      if ((c[l] <= ONE_Q14) && (o2s[l] <= lane_i[l].r)) begin
        lane_d[l].q     = c[l][14:0];
        lane_d[l].acc_a = c2s[l];
        lane_d[l].acc_b = cs[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_i;
    lane_q <= lane_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign s_o     = s_q;
  assign lane_o  = lane_q;
  assign side_o  = side_q;

endmodule

@@ rtl/triangle_normal_and_centroid_core.sv @@
// Top level: triangle unit normal (Q1.14) and rounded centroid, one triangle per clock.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  input    | start, busy          | vertex_a/b/c_x/y/z_i, given_normal_x/y/z_i
//  result   | result_valid_o       | unit_normal_x/y/z_o, centroid_x/y/z_o, flags
//  config   | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
// A triangle is taken on every clock with start high; busy stays low.
// Each word passes 9 front stages (edges, cross product, thresholds, centroid,
// normalize, squares), then 15 bit cells, then the output register. Results
// show for one cycle only; the receiver cannot stall.
// Reset (async, active low) clears the valid pipe and both thresholds to 0.
module triangle_normal_and_centroid_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic signed [31:0] vertex_a_x_i,
  input  logic signed [31:0] vertex_a_y_i,
  input  logic signed [31:0] vertex_a_z_i,
  input  logic signed [31:0] vertex_b_x_i,
  input  logic signed [31:0] vertex_b_y_i,
  input  logic signed [31:0] vertex_b_z_i,
  input  logic signed [31:0] vertex_c_x_i,
  input  logic signed [31:0] vertex_c_y_i,
  input  logic signed [31:0] vertex_c_z_i,
  input  logic signed [31:0] given_normal_x_i,
  input  logic signed [31:0] given_normal_y_i,
  input  logic signed [31:0] given_normal_z_i,
  output logic               result_valid_o,
  output logic signed [15:0] unit_normal_x_o,
  output logic signed [15:0] unit_normal_y_o,
  output logic signed [15:0] unit_normal_z_o,
  output logic signed [31:0] centroid_x_o,
  output logic signed [31:0] centroid_y_o,
  output logic signed [31:0] centroid_z_o,
  output logic               normal_was_computed_o,
  output logic               degenerate_o
);
  import tnc_pkg::*;

  logic [31:0] gmin_q, cmin_q;
  logic        accept;

  logic [2:0][31:0] va, vb, vc, gn;

  logic            ch_valid [NUM_CELLS+1];
  logic [63:0]     ch_s     [NUM_CELLS+1];
  tnc_lane_t [2:0] ch_lane  [NUM_CELLS+1];
  tnc_side_t       ch_side  [NUM_CELLS+1];

  logic [2:0][15:0] nrm_d;
  logic             rv_q;
  logic [2:0][15:0] nrm_q;
  tnc_side_t        out_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // thresholds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gmin_q <= '0;
      cmin_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GIVEN_MIN: gmin_q <= cfg_wdata_i;
        REG_CROSS_MIN: cmin_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign va = {vertex_a_z_i, vertex_a_y_i, vertex_a_x_i};
  assign vb = {vertex_b_z_i, vertex_b_y_i, vertex_b_x_i};
  assign vc = {vertex_c_z_i, vertex_c_y_i, vertex_c_x_i};
  assign gn = {given_normal_z_i, given_normal_y_i, given_normal_x_i};

  tnc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .va_i    (va),
    .vb_i    (vb),
    .vc_i    (vc),
    .gn_i    (gn),
    .gmin_i  (gmin_q),
    .cmin_i  (cmin_q),
    .valid_o (ch_valid[0]),
    .s_o     (ch_s[0]),
    .lane_o  (ch_lane[0]),
    .side_o  (ch_side[0])
  );

  // bit cells, MSB first: each settles one quotient bit of all three lanes
  for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
    tnc_cell #(.BIT(NUM_CELLS - 1 - j)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (ch_valid[j]),
      .s_i     (ch_s[j]),
      .lane_i  (ch_lane[j]),
      .side_i  (ch_side[j]),
      .valid_o (ch_valid[j+1]),
      .s_o     (ch_s[j+1]),
      .lane_o  (ch_lane[j+1]),
      .side_o  (ch_side[j+1])
    );
  end

  // sign after rounding; degenerate or zero-length forces zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ch_side[NUM_CELLS].zero) begin
        nrm_d[i] = 16'd0;
      end else if (ch_lane[NUM_CELLS][i].neg) begin
        nrm_d[i] = 16'd0 - {1'b0, ch_lane[NUM_CELLS][i].q};
      end else begin
        nrm_d[i] = {1'b0, ch_lane[NUM_CELLS][i].q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else begin
      rv_q <= ch_valid[NUM_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    nrm_q <= nrm_d;
    out_q <= ch_side[NUM_CELLS];
  end

  assign result_valid_o        = rv_q;
  assign unit_normal_x_o       = nrm_q[0];
  assign unit_normal_y_o       = nrm_q[1];
  assign unit_normal_z_o       = nrm_q[2];
  assign centroid_x_o          = out_q.cen[0];
  assign centroid_y_o          = out_q.cen[1];
  assign centroid_z_o          = out_q.cen[2];
  assign normal_was_computed_o = out_q.computed;
  assign degenerate_o          = out_q.degen;

endmodule

@@ rtl/tnc_checker.sv @@
// Port-level checks for the triangle normal and centroid core, bound to the top.
module tnc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               result_valid_o,
  input logic signed [15:0] unit_normal_x_o,
  input logic signed [15:0] unit_normal_y_o,
  input logic signed [15:0] unit_normal_z_o,
  input logic               normal_was_computed_o,
  input logic               degenerate_o
);
  import tnc_pkg::*;

  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, LATENCY))
    else $error("result word without a triangle taken");

  a_deg_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && degenerate_o) |-> normal_was_computed_o)
    else $error("degenerate without computed normal");

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && degenerate_o) |->
      (unit_normal_x_o == 16'sd0 && unit_normal_y_o == 16'sd0 && unit_normal_z_o == 16'sd0))
    else $error("degenerate normal not zero");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (unit_normal_x_o <= 16'sd16384 && unit_normal_x_o >= -16'sd16384 &&
                        unit_normal_y_o <= 16'sd16384 && unit_normal_y_o >= -16'sd16384 &&
                        unit_normal_z_o <= 16'sd16384 && unit_normal_z_o >= -16'sd16384))
    else $error("normal component out of Q1.14 range");

endmodule

bind triangle_normal_and_centroid_core tnc_checker u_tnc_checker (.*);
